FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL top level.
// Plain text macros, no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous active-low reset disable.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same-cycle implication on clk_i / rst_ni.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, (ante) |-> (cons), msg)

// Next-cycle implication on clk_i / rst_ni.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, (ante) |=> (cons), msg)

`endif

FILE: rtl/iva_pkg.sv
// Types and codes of the integer vector ALU.
// No dependencies; used by the interfaces and the top level.
package iva_pkg;

  typedef logic [2:0] op_t;
  typedef logic [1:0] sts_t;

  // Operation codes
  localparam op_t OP_ADD = 3'd0;
  localparam op_t OP_SUB = 3'd1;
  localparam op_t OP_MUL = 3'd2;
  localparam op_t OP_DIV = 3'd3;
  localparam op_t OP_DOT = 3'd4;

  // Result status codes
  localparam sts_t ST_ELEM = 2'd0;
  localparam sts_t ST_DIV0 = 2'd1;
  localparam sts_t ST_DOT  = 2'd2;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] elem_a;
    logic signed [31:0] elem_b;
    logic               last_elem;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] value;
    sts_t               status;
    logic               last_result;
  } out_item_t;

endpackage

FILE: rtl/iva_if.sv
// Valid/ready channel interfaces for element and result transactions.
// Depends on iva_pkg.
interface iva_in_if;
  import iva_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface iva_out_if;
  import iva_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/integer_vector_alu.sv
// Integer vector ALU top level: sequencer around one shared adder.
// Depends on iva_pkg, iva_if.sv and assert_macros.svh.
//
// Usage:
//  in_i carries one element pair per transaction (op, elem_a, elem_b,
//  last_elem); out_o carries zero or one result per element (value,
//  status, last_result). Both are valid/ready channels.
//  Steps: add/sub ALU, DONE; mul/div ABSA, ABSB, MUL or DIV, SIGN, DONE;
//    dot ABSA, ABSB, MUL, SIGN, ACC, then DONE only on the last element.
//    Divide by zero goes straight to DONE; aborted vectors and unused
//    codes give no result. A new element is taken only in IDLE, after
//  the previous one is done. The radix-2 shift-add multiply and
//  restoring divide loops do one bit per cycle through the single
//  UW-bit adder that also does add/sub, sign fixes and accumulation.
//  Result register: a finished result waits in out_o while the next
//  element is accepted; if out_o stalls, a new result waits in DONE and
//  in_i.ready stays low until the output register frees up.
//  Reset: asynchronous, clears the sequencer, the dot-product accumulator,
//  the abort mark and the output valid.
`include "assert_macros.svh"

module integer_vector_alu #(
  parameter int DATA_WIDTH = 32,
  parameter int ACC_WIDTH  = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  iva_in_if.sink            in_i,
  iva_out_if.source         out_o
);
  import iva_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DATA_WIDTH;                    // full product width
  localparam int UW = (PW > ACC_WIDTH) ? PW : ACC_WIDTH; // shared adder width
  localparam int CW = $clog2(DATA_WIDTH);

  typedef enum logic [3:0] {
    S_IDLE, S_ALU, S_ABSA, S_ABSB, S_MUL, S_DIV, S_SIGN, S_ACC, S_DONE
  } state_e;

  state_e                  state_q, state_d;
  op_t                     op_q, op_d;
  logic                    last_q, last_d;
  logic                    neg_q, neg_d;
  logic signed [DW-1:0]    a_q, a_d, b_q, b_d;
  logic [DW-1:0]           mcand_q, mcand_d;   // multiplicand or divisor magnitude
  logic [PW-1:0]           work_q, work_d;     // {partial/remainder, multiplier/quotient}
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [ACC_WIDTH-1:0]    dot_sum_q, dot_sum_d;
  logic                    aborted_q, aborted_d;
  out_item_t               pend_q, pend_d;     // result waiting for the output register
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_data_q, out_data_d;

  // Shared adder
  logic [UW-1:0]           add_x, add_y, add_s;
  logic                    add_ci;
  logic [DW:0]             hi_shift;
  logic [PW-1:0]           sign_src;

  logic                    in_fire, out_fire, out_free;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;
  assign out_fire    = out_valid_q && out_o.ready;
  assign out_free    = !out_valid_q || out_o.ready;

  // remainder shifted left with the next dividend bit
  assign hi_shift = work_q[PW-1:DW-1];
  assign sign_src = (op_q == OP_DIV) ? {{DW{1'b0}}, work_q[DW-1:0]} : work_q;

  assign add_s = add_x + add_y + UW'(add_ci);

  // Operand select for the shared adder
  always_comb begin
    add_x  = '0;
    add_y  = '0;
    add_ci = 1'b0;
    case (state_q)
      S_ALU: begin
        add_x = UW'(a_q);
        if (op_q == OP_SUB) begin
          add_y  = ~UW'(b_q);
          add_ci = 1'b1;
        end else begin
          add_y = UW'(b_q);
        end
      end
      S_ABSA: begin
        add_y  = ~UW'(a_q);
        add_ci = 1'b1;
      end
      S_ABSB: begin
        add_y  = ~UW'(b_q);
        add_ci = 1'b1;
      end
      S_MUL: begin
        add_x = UW'(work_q[PW-1:DW]);
        add_y = work_q[0] ? UW'(mcand_q) : '0;
      end
      S_DIV: begin
        add_x  = UW'(hi_shift);
        add_y  = ~UW'(mcand_q);
        add_ci = 1'b1;
      end
      S_SIGN: begin
        if (neg_q) begin
          add_y  = ~UW'(sign_src);
          add_ci = 1'b1;
        end else begin
          add_x = UW'(sign_src);
        end
      end
      S_ACC: begin
        add_x = UW'(dot_sum_q);
        add_y = UW'($signed(work_q));
      end
      default: begin
        add_x = '0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    logic [DW-1:0] bmag;

    bmag        = b_q[DW-1] ? add_s[DW-1:0] : b_q;
    state_d     = state_q;
    op_d        = op_q;
    last_d      = last_q;
    neg_d       = neg_q;
    a_d         = a_q;
    b_d         = b_q;
    mcand_d     = mcand_q;
    work_d      = work_q;
    cnt_d       = cnt_q;
    dot_sum_d   = dot_sum_q;
    aborted_d   = aborted_q;
    pend_d      = pend_q;
    out_valid_d = out_fire ? 1'b0 : out_valid_q;
    out_data_d  = out_data_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d   = in_i.data.op;
          last_d = in_i.data.last_elem;
          a_d    = in_i.data.elem_a[DW-1:0];
          b_d    = in_i.data.elem_b[DW-1:0];
          neg_d  = in_i.data.elem_a[DW-1] ^ in_i.data.elem_b[DW-1];
          if (aborted_q) begin
            // rest of an aborted vector is dropped
            if (in_i.data.last_elem) begin
              aborted_d = 1'b0;
              dot_sum_d = '0;
            end
          end else begin
            case (in_i.data.op)
              OP_ADD, OP_SUB: begin
                state_d = S_ALU;
                if (in_i.data.last_elem) dot_sum_d = '0;
              end
              OP_MUL: begin
                state_d = S_ABSA;
                if (in_i.data.last_elem) dot_sum_d = '0;
              end
              OP_DIV: begin
                if (in_i.data.last_elem) dot_sum_d = '0;
                if (in_i.data.elem_b[DW-1:0] == '0) begin
                  pend_d.value       = '0;
                  pend_d.status      = ST_DIV0;
                  pend_d.last_result = 1'b1;
                  state_d            = S_DONE;
                  if (!in_i.data.last_elem) aborted_d = 1'b1;
                end else begin
                  state_d = S_ABSA;
                end
              end
              OP_DOT: begin
                state_d = S_ABSA;
              end
              default: begin
                if (in_i.data.last_elem) dot_sum_d = '0;
              end
            endcase
          end
        end
      end
      S_ALU: begin
        pend_d.value       = 64'(signed'(add_s[DW-1:0]));
        pend_d.status      = ST_ELEM;
        pend_d.last_result = last_q;
        state_d            = S_DONE;
      end
      S_ABSA: begin
        mcand_d = a_q[DW-1] ? add_s[DW-1:0] : a_q;
        state_d = S_ABSB;
      end
      S_ABSB: begin
        cnt_d = CW'(DW - 1);
        if (op_q == OP_DIV) begin
          work_d  = {{DW{1'b0}}, mcand_q};
          mcand_d = bmag;
          state_d = S_DIV;
        end else begin
          work_d  = {{DW{1'b0}}, bmag};
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        work_d = {add_s[DW:0], work_q[DW-1:1]};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = S_SIGN;
      end
      S_DIV: begin
        if (add_s[UW-1]) begin
          work_d = {work_q[PW-2:0], 1'b0};
        end else begin
          work_d = {add_s[DW-1:0], work_q[DW-2:0], 1'b1};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = S_SIGN;
      end
      S_SIGN: begin
        work_d = add_s[PW-1:0];
        if (op_q == OP_DOT) begin
          state_d = S_ACC;
        end else begin
          pend_d.value       = 64'(signed'(add_s[DW-1:0]));
          pend_d.status      = ST_ELEM;
          pend_d.last_result = last_q;
          state_d            = S_DONE;
        end
      end
      S_ACC: begin
        if (last_q) begin
          dot_sum_d          = '0;
          pend_d.value       = 64'(signed'(add_s[ACC_WIDTH-1:0]));
          pend_d.status      = ST_DOT;
          pend_d.last_result = 1'b1;
          state_d            = S_DONE;
        end else begin
          dot_sum_d = add_s[ACC_WIDTH-1:0];
          state_d   = S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = pend_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_ADD;
      last_q      <= 1'b0;
      neg_q       <= 1'b0;
      a_q         <= '0;
      b_q         <= '0;
      mcand_q     <= '0;
      work_q      <= '0;
      cnt_q       <= '0;
      dot_sum_q   <= '0;
      aborted_q   <= 1'b0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      last_q      <= last_d;
      neg_q       <= neg_d;
      a_q         <= a_d;
      b_q         <= b_d;
      mcand_q     <= mcand_d;
      work_q      <= work_d;
      cnt_q       <= cnt_d;
      dot_sum_q   <= dot_sum_d;
      aborted_q   <= aborted_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  // Last element of an aborted vector ends the abort
  `ASSERT_NEXT(a_abort_clear, in_fire && aborted_q && in_i.data.last_elem, !aborted_q,
    "abort mark not cleared by last element")
  // Dot sum reported on the last element leaves a clean accumulator
  `ASSERT_NEXT(a_dot_clear, state_q == S_ACC && last_q, dot_sum_q == '0,
    "accumulator not cleared after dot result")
  // Output register is only loaded from the DONE state
  `ASSERT_IMPL(a_out_src, $rose(out_valid_q), $past(state_q) == S_DONE,
    "result transaction raised outside DONE")

endmodule
